[rtl/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg - shared definitions for the 3x3 median filter
// Default sizes, configuration register indexes, reset values and the
// control structures that pass between the filter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	// Default sizes handed to the top level's parameters.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int FRAME_W_W   = 11;
	localparam int FRAME_H_W   = 13;

	// Row counter covers the tallest frame that is allowed.
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;

	// Frame size after reset.
	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 480;

	// Smallest frame in either direction.
	localparam int MIN_SIDE = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// Line store strobes for one cycle.
	typedef struct packed {
		logic rd_en;     // read both lines and write the new pixel to the middle line
		logic up_wr_en;  // write the old middle line value to the upper line
	} lb_ctrl_t;

	// Control that travels with a pixel through the first stage.
	typedef struct packed {
		logic emit;      // window lies fully inside the frame
		logic last;      // last pixel of the frame
		logic has_mid;   // row one or later: middle line is valid
		logic has_up;    // row two or later: upper line is valid
	} s1_ctrl_t;

endpackage

`default_nettype wire

[rtl/median_filter_3x3_top.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_top - streaming 3x3 median filter
// Takes gray pixels in raster order and gives the median of every 3x3
// window that lies fully inside the frame, the last one of a frame marked.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ------------------------------
//  input     in         in_valid / in_ready    pixel
//  output    out        out_valid / out_ready  median, frame_done
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is taken in every clock cycle unless the pipeline stalls. A pixel
// passes through the line store read stage and its result is then loaded
// into the output register, which raises out_valid.
// Border pixels make no result and leave the output channel silent.
// The pipeline stalls only while a result waits in the output register and
// the first stage is full; input ready then drops until the result is taken.
// Reset clears the counts, the valid flags and the frame size (640 by 480);
// the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_top #(
	parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Pixel input
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [PIXEL_BITS-1:0]          pixel,
	// Result output
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [PIXEL_BITS-1:0]          median,
	output logic                                frame_done,
	// Configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mf3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	// The reset width is clamped to the line store depth like any other.
	localparam int RST_W        = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
	localparam int RST_LAST_COL = RST_W - 1;
	localparam int RST_LAST_ROW = RST_FRAME_HEIGHT - 1;

	localparam logic [CFG_DATA_W-1:0] MAX_W_CMP  = CFG_DATA_W'(MAX_WIDTH);
	localparam logic [FRAME_H_W-1:0]  MAX_H_CMP  = FRAME_H_W'(MAX_HEIGHT);
	localparam logic [FRAME_W_W-1:0]  MIN_W_CMP  = FRAME_W_W'(MIN_SIDE);
	localparam logic [FRAME_H_W-1:0]  MIN_H_CMP  = FRAME_H_W'(MIN_SIDE);

	// The frame size is kept as the index of the last column and last row,
	// already clamped into range when it is written.
	logic [COL_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;

	// Position of the next pixel to arrive.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// First stage: pixel and its control, alongside the registered line reads.
	logic                  s1_valid_s1;
	s1_ctrl_t              s1_ctrl_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [COL_W-1:0]      col_s1;
	logic [PIXEL_BITS-1:0] mid_rd_s1;
	logic [PIXEL_BITS-1:0] up_rd_s1;

	// Output register.
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] median_q;
	logic                  frame_done_q;

	logic                  in_xfer;
	logic                  cfg_xfer;
	logic                  out_free;
	logic                  s1_move;
	logic                  col_wrap;
	s1_ctrl_t              s1_ctrl_next;
	lb_ctrl_t              lb_ctrl;
	logic [PIXEL_BITS-1:0] col_mid;
	logic [PIXEL_BITS-1:0] col_up;
	logic [PIXEL_BITS-1:0] median_next;
	logic [FRAME_W_W-1:0]  cfg_width;
	logic [FRAME_H_W-1:0]  cfg_height;
	logic [COL_W-1:0]      new_last_col;
	logic [ROW_W-1:0]      new_last_row;

	// Handshakes. The output register can take a new entry when it is empty
	// or its result is being taken; the first stage then always drains, so
	// the input side is held back only by a stalled result and a full stage.
	assign out_free  = !out_valid_q || out_ready;
	assign s1_move   = s1_valid_s1 && out_free;
	assign in_ready  = !s1_valid_s1 || out_free;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid;

	assign out_valid  = out_valid_q;
	assign median     = median_q;
	assign frame_done = frame_done_q;

	// Clamp a newly written frame size into its legal range.
	assign cfg_width  = cfg_data[FRAME_W_W-1:0];
	assign cfg_height = cfg_data[FRAME_H_W-1:0];

	always_comb begin
		if (cfg_width < MIN_W_CMP) begin
			new_last_col = COL_W'(MIN_SIDE - 1);
		end else if ({{(CFG_DATA_W-FRAME_W_W){1'b0}}, cfg_width} > MAX_W_CMP) begin
			new_last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			new_last_col = COL_W'(cfg_width - FRAME_W_W'(1));
		end

		if (cfg_height < MIN_H_CMP) begin
			new_last_row = ROW_W'(MIN_SIDE - 1);
		end else if (cfg_height > MAX_H_CMP) begin
			new_last_row = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			new_last_row = ROW_W'(cfg_height - FRAME_H_W'(1));
		end
	end

	// Window position decides whether the pixel completes an interior window,
	// and which line reads hold data from the current frame.
	assign col_wrap = (col_q == last_col_q);

	always_comb begin
		s1_ctrl_next.has_mid = (row_q != '0);
		s1_ctrl_next.has_up  = (row_q > ROW_W'(1));
		s1_ctrl_next.emit    = (row_q > ROW_W'(1)) && (col_q > COL_W'(1));
		s1_ctrl_next.last    = col_wrap && (row_q == last_row_q);
	end

	// Configuration registers and the raster position. Any register write
	// restarts the frame; a write beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= COL_W'(RST_LAST_COL);
			last_row_q <= ROW_W'(RST_LAST_ROW);
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_xfer) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					last_col_q <= new_last_col;
					col_q      <= '0;
					row_q      <= '0;
				end
				REG_FRAME_HEIGHT: begin
					last_row_q <= new_last_row;
					col_q      <= '0;
					row_q      <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_xfer) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line stores: both lines are read at the current column on a transfer,
	// and the middle line takes the new pixel there. The value read from the
	// middle line moves up a line as the pixel leaves the first stage.
	always_comb begin
		lb_ctrl.rd_en    = in_xfer;
		lb_ctrl.up_wr_en = s1_move;
	end

	assign col_mid = s1_ctrl_s1.has_mid ? mid_rd_s1 : '0;
	assign col_up  = s1_ctrl_s1.has_up  ? up_rd_s1  : '0;

	mf3_line_buf #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_buf (
		.clk        (clk),
		.ctrl       (lb_ctrl),
		.rd_addr    (col_q),
		.wr_px      (pixel),
		.up_wr_addr (col_s1),
		.up_wr_data (col_mid),
		.mid_rd_s1  (mid_rd_s1),
		.up_rd_s1   (up_rd_s1)
	);

	// The window shifts by one column each time a pixel leaves the first
	// stage, so it follows the raster order exactly.
	mf3_median #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_median (
		.clk         (clk),
		.load        (s1_move),
		.col_up      (col_up),
		.col_mid     (col_mid),
		.col_px      (px_s1),
		.median_next (median_next)
	);

	// First stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s1_ctrl_s1 <= s1_ctrl_next;
			px_s1      <= pixel;
			col_s1     <= col_q;
		end
	end

	// Output register. A border pixel passes through without making a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1 && s1_ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			median_q     <= median_next;
			frame_done_q <= s1_ctrl_s1.last;
		end
	end

endmodule

`default_nettype wire

[rtl/mf3_line_buf.sv]
// ----------------------------------------------------------------------------
// mf3_line_buf - the two line stores
// Holds the two previous image rows. The read data is registered and the
// middle line takes the incoming pixel at the same address in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_buf #(
	parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                          clk,
	input  wire mf3_pkg::lb_ctrl_t             ctrl,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  wire logic [PIXEL_BITS-1:0]         wr_px,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  up_wr_addr,
	input  wire logic [PIXEL_BITS-1:0]         up_wr_data,
	output logic      [PIXEL_BITS-1:0]         mid_rd_s1,
	output logic      [PIXEL_BITS-1:0]         up_rd_s1
);
	import mf3_pkg::*;

	logic [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] up_mem  [MAX_WIDTH];

	// Read-first: a read and a write at the same address return the old value.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			mid_rd_s1        <= mid_mem[rd_addr];
			up_rd_s1         <= up_mem[rd_addr];
			mid_mem[rd_addr] <= wr_px;
		end
		if (ctrl.up_wr_en) begin
			up_mem[up_wr_addr] <= up_wr_data;
		end
	end

endmodule

`default_nettype wire

[rtl/mf3_median.sv]
// ----------------------------------------------------------------------------
// mf3_median - 3x3 window and median network
// Keeps the two older window columns already sorted, sorts the new column
// and forms the median as the middle of the largest low, the middle of the
// middles and the smallest high.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median #(
	parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  load,
	input  wire logic [PIXEL_BITS-1:0] col_up,
	input  wire logic [PIXEL_BITS-1:0] col_mid,
	input  wire logic [PIXEL_BITS-1:0] col_px,
	output logic      [PIXEL_BITS-1:0] median_next
);
	import mf3_pkg::*;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		pix_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		pix_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		pix_t lo;
		pix_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (c < lo) ? lo : ((c > hi) ? hi : c);
	endfunction

	// Older columns, index 0 the oldest, each sorted low to high.
	pix_t lo_q [2];
	pix_t md_q [2];
	pix_t hi_q [2];

	pix_t new_lo;
	pix_t new_md;
	pix_t new_hi;

	always_comb begin
		new_lo = min3(col_up, col_mid, col_px);
		new_hi = max3(col_up, col_mid, col_px);
		new_md = med3(col_up, col_mid, col_px);
		median_next = med3(max3(lo_q[0], lo_q[1], new_lo),
		                   med3(md_q[0], md_q[1], new_md),
		                   min3(hi_q[0], hi_q[1], new_hi));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lo_q[0] <= lo_q[1];
			md_q[0] <= md_q[1];
			hi_q[0] <= hi_q[1];
			lo_q[1] <= new_lo;
			md_q[1] <= new_md;
			hi_q[1] <= new_hi;
		end
	end

endmodule

`default_nettype wire

[rtl/mf3_checker.sv]
// ----------------------------------------------------------------------------
// mf3_checker - port checks for the 3x3 median filter
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_checker #(
	parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [PIXEL_BITS-1:0] median,
	input wire logic                  frame_done,
	input wire logic                  cfg_ready
);
	import mf3_pkg::*;

	default clocking cb @(posedge clk);
	endclocking

	// A result that is not taken holds still.
	a_out_hold: assert property (disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median) && $stable(frame_done))
		else $error("result changed while stalled");

	// Input is held back only by a result that waits to be taken.
	a_ready_cause: assert property (disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with the output side free");

	// A result rises only where a pixel transfer passed the first stage and the output register.
	a_out_latency: assert property (disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a pixel transfer two cycles earlier");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind median_filter_3x3_top mf3_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_mf3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.median     (median),
	.frame_done (frame_done),
	.cfg_ready  (cfg_ready)
);

`default_nettype wire

[tb/median_filter_3x3_checker.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_checker - result checker for the 3x3 median filter
// Watches the pixel, result and configuration channels, keeps its own model
// of the line stores and window, and compares every result with the median
// it expects, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [7:0]                      pixel,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [7:0]                      median,
	input  wire logic                            frame_done,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                   mismatch_count,
	output int                                   pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import mf3_pkg::*;

	typedef struct packed {
		logic [7:0] median;
		logic       frame_done;
	} filter_result_t;

	logic [FRAME_W_W-1:0] width_reg;
	logic [FRAME_H_W-1:0] height_reg;
	logic [7:0]           upper_row [DEF_MAX_WIDTH];
	logic [7:0]           middle_row [DEF_MAX_WIDTH];
	logic [7:0]           win [9];
	int unsigned          col;
	int unsigned          row;
	filter_result_t       expected_medians [$];

	// Sizes outside the supported range are pulled to the nearest limit.
	function automatic int unsigned clamp_side(input int unsigned v, input int unsigned hi);
		if (v < MIN_SIDE)
			return MIN_SIDE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// The median is the one value with at most four smaller entries and at
	// least five entries no larger than itself.
	function automatic logic [7:0] window_median();
		int lt;
		int le;
		for (int i = 0; i < 9; i++) begin
			lt = 0;
			le = 0;
			for (int j = 0; j < 9; j++) begin
				if (win[j] < win[i])
					lt++;
				if (win[j] <= win[i])
					le++;
			end
			if (lt <= 4 && le >= 5)
				return win[i];
		end
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		filter_result_t want;
		int unsigned    w;
		int unsigned    h;
		logic [7:0]     up;
		logic [7:0]     mid;
		if (!arst_n) begin
			width_reg = FRAME_W_W'(RST_FRAME_WIDTH);
			height_reg = FRAME_H_W'(RST_FRAME_HEIGHT);
			foreach (win[i])
				win[i] = '0;
			col = 0;
			row = 0;
			expected_medians.delete();
			mismatch_count = 0;
		end else begin
			// Results leave only after their pixel has passed the first stage and the
			// output register, so they are checked before the pixel of this edge is taken into the model.
			if (out_valid && out_ready) begin
				if (expected_medians.size() == 0) begin
					$error("result with no median expected: median %0d, frame_done %0d",
						median, frame_done);
					mismatch_count++;
				end else begin
					want = expected_medians.pop_front();
					if (median !== want.median) begin
						$error("median: expected %0d, actual %0d", want.median, median);
						mismatch_count++;
					end
					if (frame_done !== want.frame_done) begin
						$error("frame_done: expected %0d, actual %0d",
							want.frame_done, frame_done);
						mismatch_count++;
					end
				end
			end

			// A write to either register starts a new frame; spare indexes do nothing.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_data[FRAME_W_W-1:0];
						col = 0;
						row = 0;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_data[FRAME_H_W-1:0];
						col = 0;
						row = 0;
					end
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				w = clamp_side(width_reg, DEF_MAX_WIDTH);
				h = clamp_side(height_reg, MAX_HEIGHT);
				mid = (row >= 1) ? middle_row[col] : '0;
				up = (row >= 2) ? upper_row[col] : '0;
				win[0] = win[1];
				win[1] = win[2];
				win[2] = up;
				win[3] = win[4];
				win[4] = win[5];
				win[5] = mid;
				win[6] = win[7];
				win[7] = win[8];
				win[8] = pixel;
				upper_row[col] = mid;
				middle_row[col] = pixel;
				if (row >= 2 && col >= 2) begin
					want.median = window_median();
					want.frame_done = (row == h - 1) && (col == w - 1);
					expected_medians.push_back(want);
				end
				if (col + 1 >= w) begin
					col = 0;
					row = (row + 1 >= h) ? 0 : row + 1;
				end else begin
					col = col + 1;
				end
			end
		end
		pending_results = expected_medians.size();
	end

endmodule

`default_nettype wire

[tb/median_filter_3x3_top_tb.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_top_tb - regression bench for the 3x3 median filter
// Streams directed and random frames of pixels into the filter under random
// back-pressure, writes the frame size between phases, and lets a separate
// checker compare every median and end-of-frame flag with its own model.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mf3_pkg::*;

	// Per cent of cycles in which either side holds back.
	localparam int IDLE_PERCENT = 29;
	// Cycles allowed after the last expected result before a write or the verdict.
	localparam int DRAIN_CYCLES = 4;
	// Cycles without any transfer before the run is declared hung.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 300;
	// Frame streamed with no idling on either side.
	localparam int NO_IDLE_WIDTH  = 16;
	localparam int NO_IDLE_HEIGHT = 5;

	// Register indexes that no register answers to.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef enum int {
		PIX_UNIFORM,
		PIX_NARROW,
		PIX_EXTREME
	} pixel_mix_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             pixel;
	logic                   out_valid;
	logic                   out_ready;
	logic [7:0]             median;
	logic                   frame_done;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   mismatch_count;
	int   pending_results;
	int   stall_cycles = 0;
	// Set for the stretch in which neither side is allowed to hold back.
	logic idle_free = 1'b0;

	// One frame of the smallest size: alternating extremes around a mid grey,
	// so the median is the only value that is neither black nor white.
	logic [7:0] corner_frame [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128,
		8'd255, 8'd0, 8'd255, 8'd0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	median_filter_3x3_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.median     (median),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	median_filter_3x3_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel           (pixel),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.median          (median),
		.frame_done      (frame_done),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// The receiver stalls at random, except during the stretch with no idling.
	// Like every other input it changes only on the falling edge.
	always @(negedge clk)
		out_ready <= idle_free || ($urandom_range(0, 99) >= IDLE_PERCENT);

	// Watchdog: any transfer on any channel resets the count, so only a
	// genuine hang can reach the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("median_filter_3x3_top regression: fail");
			$finish;
		end
	end

	// The effective frame side, needed here only to size whole frames.
	function automatic int frame_side(input int v, input int hi);
		if (v < MIN_SIDE)
			return MIN_SIDE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [7:0] make_pixel(input pixel_mix_t mix);
		case (mix)
			// A narrow band gives many equal values and so ties in the sort.
			PIX_NARROW:  return 8'($urandom_range(120, 123));
			PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:     return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one pixel and returns on the falling edge after its transfer.
	// Valid is left high, so a following pixel goes out without a gap unless
	// the random idling decides otherwise.
	task automatic send_pixel(input logic [7:0] value);
		while (!idle_free && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops the pixel stream and waits until every expected median has been
	// seen, then waits on for a border pixel that may still be in the pipeline.
	task automatic drain_filter();
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// Leaves cfg_valid high after the transfer so that back-to-back writes
	// need no second assignment in the same step; the caller lowers it.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input int w_val, input int h_val);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_val));
			write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
		end else begin
			write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
			write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_val));
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int         w_val;
		int         h_val;
		int         w;
		int         h;
		int         count;
		int         random_items;
		pixel_mix_t mix;

		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		out_ready = 1'b0;
		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. With the reset size of 640 by 480, the first two
		// pixels sit in row 0 and must give nothing.
		send_pixel(8'h00);
		send_pixel(8'hFF);
		drain_filter();

		// The smallest frame: a write restarts the frame, and exactly one
		// median comes out, marked as the last of the frame.
		configure(MIN_SIDE, MIN_SIDE);
		foreach (corner_frame[i])
			send_pixel(corner_frame[i]);
		drain_filter();

		// Half a frame, then a pause until everything has drained, then writes
		// to the spare indexes. These must not restart the frame, so the rest
		// of the pixels still complete it.
		repeat (4)
			send_pixel(make_pixel(PIX_UNIFORM));
		drain_filter();
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '0);
		cfg_valid <= 1'b0;
		repeat (5)
			send_pixel(make_pixel(PIX_EXTREME));
		drain_filter();

		// Both sizes below their range: the filter treats them as three.
		configure(0, 1);
		repeat (9)
			send_pixel(make_pixel(PIX_NARROW));
		drain_filter();

		// A whole frame streamed with no idling on either side, so pixels
		// and medians move back to back.
		idle_free = 1'b1;
		configure(NO_IDLE_WIDTH, NO_IDLE_HEIGHT);
		repeat (NO_IDLE_WIDTH * NO_IDLE_HEIGHT)
			send_pixel(make_pixel(PIX_UNIFORM));
		drain_filter();
		idle_free = 1'b0;

		configure(2, 0);
		w = MIN_SIDE;
		h = MIN_SIDE;

		// Random part. Mostly whole frames of small sizes, sometimes one or
		// two back to back; the rest are frames cut short by the next write,
		// or phases that keep the old size and carry on mid-frame.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0:       w_val = $urandom_range(0, MIN_SIDE - 1);
					1:       w_val = $urandom_range(13, 24);
					default: w_val = $urandom_range(MIN_SIDE, 12);
				endcase
				case ($urandom_range(0, 9))
					0:       h_val = $urandom_range(0, MIN_SIDE - 1);
					1:       h_val = $urandom_range(9, 12);
					default: h_val = $urandom_range(MIN_SIDE, 8);
				endcase
				configure(w_val, h_val);
				w = frame_side(w_val, DEF_MAX_WIDTH);
				h = frame_side(h_val, MAX_HEIGHT);
			end
			if ($urandom_range(0, 4) != 0)
				count = w * h * $urandom_range(1, 2);
			else
				count = $urandom_range(1, w * h - 1);
			// The last phase is cut short so the total stays near the target.
			if (count > RANDOM_ITEMS - random_items)
				count = RANDOM_ITEMS - random_items;
			mix = pixel_mix_t'($urandom_range(0, 2));
			repeat (count) begin
				// Now and then the sender waits for every median to arrive.
				if ($urandom_range(0, 79) == 0)
					drain_filter();
				send_pixel(make_pixel(mix));
			end
			random_items += count;
			drain_filter();
		end

		if (mismatch_count == 0)
			$display("median_filter_3x3_top regression: pass");
		else
			$display("median_filter_3x3_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/mf3_pkg.sv
rtl/mf3_line_buf.sv
rtl/mf3_median.sv
rtl/median_filter_3x3_top.sv
rtl/mf3_checker.sv
tb/median_filter_3x3_checker.sv
tb/median_filter_3x3_top_tb.sv
